// ----- design/rgbe_pkg.sv -----
package rgbe_pkg;
    localparam logic CMD_ENCODE = 1'b0;
    localparam logic CMD_DECODE = 1'b1;
    localparam int   EXCESS     = 128;

    typedef struct packed {
        logic        command;
        logic [31:0] red_in;
        logic [31:0] green_in;
        logic [31:0] blue_in;
        logic [7:0]  mant_red_in;
        logic [7:0]  mant_green_in;
        logic [7:0]  mant_blue_in;
        logic [7:0]  expo_in;
    } t_req;

    typedef struct packed {
        logic [31:0] red_out;
        logic [31:0] green_out;
        logic [31:0] blue_out;
        logic [7:0]  mant_red_out;
        logic [7:0]  mant_green_out;
        logic [7:0]  mant_blue_out;
        logic [7:0]  expo_out;
        logic        range_error;
    } t_rsp;

    // positive floats order like integers, so the tiny test is a compare of the bits
    localparam logic [30:0] TINY_BITS = 31'h0A4F_B11E; // bits of largest float <= 1e-32

    // decode one mantissa byte to float bits: (2m+1)*2^(ex-137)
    function automatic logic [31:0] dec_one(input logic [7:0] m, input logic [7:0] ex);
        logic [8:0] v;
        logic [3:0] msb;
        logic [8:0] e;
        logic [22:0] frac;
        begin
            v = {m, 1'b1};
            msb = 4'd0;
            for (int k = 0; k < 9; k++) begin
                if (v[k]) msb = 4'(k);
            end
            // value = 1.f * 2^(msb + ex - 137), biased = msb + ex - 10
            e = 9'({1'b0, ex}) + 9'(msb) - 9'd10;
            frac = 23'(({14'd0, v} << (5'd23 - 5'(msb))) & 23'h7FFFFF);
            // small exponent bytes give a denormal: fraction = v * 2^(ex+12)
            if (e[8] || e == 9'd0) dec_one = {9'd0, 23'({14'd0, v} << (ex + 8'd12))};
            else dec_one = {1'b0, e[7:0], frac};
        end
    endfunction
endpackage

// ----- design/rgbe_stream_if.sv -----
interface rgbe_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// ----- design/rgbe_shared_exponent_codec.sv -----
// rgbe shared exponent codec
// channels: i_req (sink) carries one request per pixel with a command bit:
//   encode takes three float32 colors and returns three mantissa bytes,
//   an exponent byte and a range error flag; decode takes an rgbe pixel and
//   returns three float32 colors. unused result fields are zero.
// latency: four register stages, the last of which is the output register.
// throughput: one request per cycle; the four stage pipeline advances when
//   the output register is empty or being taken.
// stage 1: sign clamp, non-finite detect; stage 2: max compare;
// stage 3: range and tiny checks, decode float assembly; stage 4: shift amounts and mantissa shift.
// reset clears all stage valid bits; payload registers are not reset.
// when the receiver stalls, the whole pipeline holds and ready drops; no
//   request is lost or repeated.
module rgbe_shared_exponent_codec
    import rgbe_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    rgbe_stream_if.sink   i_req,
    rgbe_stream_if.source o_rsp
);
    logic adv;
    assign adv = !o_rsp.valid || o_rsp.ready;
    assign i_req.ready = adv;

    logic [3:0] r_vld;

    // stage 1 registers
    logic        r1_cmd, r1_nf;
    logic [30:0] r1_v [3];
    logic [7:0]  r1_m [3];
    logic [7:0]  r1_ex;
    // stage 2
    logic        r2_cmd, r2_nf;
    logic [30:0] r2_v [3];
    logic [30:0] r2_mx;
    logic [7:0]  r2_m [3];
    logic [7:0]  r2_ex;
    // stage 3
    logic        r3_cmd, r3_err, r3_zero;
    logic [30:0] r3_v [3];
    logic [7:0]  r3_mxe;
    logic [31:0] r3_f [3];
    // output
    t_rsp r_rsp;
    t_rsp n_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= 4'd0;
        else if (adv) r_vld <= {r_vld[2:0], i_req.valid};
    end

    // stage 1: clamp negatives, flag non-finite
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_cmd <= i_req.data.command;
            r1_nf  <= (&i_req.data.red_in[30:23]) || (&i_req.data.green_in[30:23])
                   || (&i_req.data.blue_in[30:23]);
            r1_v[0] <= i_req.data.red_in[31]   ? 31'd0 : i_req.data.red_in[30:0];
            r1_v[1] <= i_req.data.green_in[31] ? 31'd0 : i_req.data.green_in[30:0];
            r1_v[2] <= i_req.data.blue_in[31]  ? 31'd0 : i_req.data.blue_in[30:0];
            r1_m[0] <= i_req.data.mant_red_in;
            r1_m[1] <= i_req.data.mant_green_in;
            r1_m[2] <= i_req.data.mant_blue_in;
            r1_ex   <= i_req.data.expo_in;
        end
    end

    // stage 2: largest component (positive floats compare as integers)
    logic [30:0] n_mx01;
    always_comb n_mx01 = (r1_v[1] > r1_v[0]) ? r1_v[1] : r1_v[0];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_cmd <= r1_cmd;
            r2_nf  <= r1_nf;
            r2_v   <= r1_v;
            r2_mx  <= (r1_v[2] > n_mx01) ? r1_v[2] : n_mx01;
            r2_m   <= r1_m;
            r2_ex  <= r1_ex;
        end
    end

    // stage 3: exponent checks, decode assembly
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_cmd  <= r2_cmd;
            r3_err  <= r2_nf || (r2_mx[30:23] == 8'hFE);
            r3_zero <= r2_mx <= TINY_BITS;
            r3_v    <= r2_v;
            r3_mxe  <= r2_mx[30:23];
            for (int i = 0; i < 3; i++)
                r3_f[i] <= (r2_ex == 8'd0) ? 32'd0 : dec_one(r2_m[i], r2_ex);
        end
    end

    // stage 4: mantissa byte = floor(v * 2^(8-e)), e = mxe-126
    function automatic logic [7:0] enc_one(input logic [30:0] v, input logic [7:0] mxe);
        logic [8:0]  d;
        logic [23:0] sig;
        logic [31:0] sh;
        begin
            // m = sig * 2^(ve-150+8-mxe+126) = sig >> (mxe - ve + 16)
            sig = (v[30:23] == 8'd0) ? {1'b0, v[22:0]} : {1'b1, v[22:0]};
            d = 9'(mxe) - 9'((v[30:23] == 8'd0) ? 8'd1 : v[30:23]) + 9'd16;
            if (d > 9'd31) enc_one = 8'd0;
            else begin
                sh = {8'd0, sig} >> d[4:0];
                enc_one = sh[7:0];
            end
        end
    endfunction

    // result selection for the output register
    always_comb begin
        n_rsp = '0;
        if (r3_cmd == CMD_DECODE) begin
            n_rsp.red_out   = r3_f[0];
            n_rsp.green_out = r3_f[1];
            n_rsp.blue_out  = r3_f[2];
        end else if (r3_err) begin
            n_rsp.range_error = 1'b1;
        end else if (!r3_zero) begin
            n_rsp.mant_red_out   = enc_one(r3_v[0], r3_mxe);
            n_rsp.mant_green_out = enc_one(r3_v[1], r3_mxe);
            n_rsp.mant_blue_out  = enc_one(r3_v[2], r3_mxe);
            n_rsp.expo_out       = 8'(9'(r3_mxe) + 9'd2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) r_rsp <= n_rsp;
    end

    assign o_rsp.valid = r_vld[3];
    assign o_rsp.data  = r_rsp;
endmodule

// ----- tb/sv/tb_rgbe_if_note.sv -----
`timescale 1ns / 100ps
// shared helpers for the codec testbench
package tb_rgbe_pkg;
    import rgbe_pkg::*;

    // float32 with biased exponent field: infinity and nan both have all ones
    function automatic bit is_nonfinite(input logic [31:0] b);
        return b[30:23] == 8'hFF;
    endfunction

    // expected result of one pixel request
    function automatic t_rsp predict_pixel(input t_req r);
        t_rsp o;
        logic [31:0] c [3];
        logic [31:0] mx;
        int unsigned ex, sh;
        int p;
        logic [23:0] sig;
        logic [8:0] v;
        int msb;
        o = '0;
        if (r.command == CMD_ENCODE) begin
            c[0] = r.red_in;
            c[1] = r.green_in;
            c[2] = r.blue_in;
            if (is_nonfinite(c[0]) || is_nonfinite(c[1]) || is_nonfinite(c[2])) begin
                o.range_error = 1'b1;
                return o;
            end
            // negative clamps to zero; positive floats order like integers
            foreach (c[i]) if (c[i][31]) c[i] = '0;
            mx = c[0];
            if (c[1] > mx) mx = c[1];
            if (c[2] > mx) mx = c[2];
            if (mx[30:0] <= 31'h0A4F_B11E) return o;
            ex = mx[30:23];
            if (ex - 126 + 128 > 255) begin
                o.range_error = 1'b1;
                return o;
            end
            // m = sig * 2^(ce-150) * 2^(8-(ex-126)) = sig * 2^(ce - ex - 16)
            for (int i = 0; i < 3; i++) begin
                logic [7:0] q;
                q = '0;
                if (c[i][30:23] != 0) begin
                    sig = {1'b1, c[i][22:0]};
                    sh = ex + 16 - c[i][30:23];
                    q = (sh >= 24) ? 8'd0 : 8'(sig >> sh);
                end else if (ex + 15 < 24) begin
                    q = 8'({1'b0, c[i][22:0]} >> (ex + 15));
                end
                if (i == 0) o.mant_red_out = q;
                else if (i == 1) o.mant_green_out = q;
                else o.mant_blue_out = q;
            end
            o.expo_out = 8'(ex + 2);
        end else if (r.expo_in != 0) begin
            for (int i = 0; i < 3; i++) begin
                logic [31:0] f;
                v = {(i == 0) ? r.mant_red_in : (i == 1) ? r.mant_green_in : r.mant_blue_in,
                     1'b1};
                msb = 0;
                for (int k = 0; k < 9; k++) if (v[k]) msb = k;
                p = int'(r.expo_in) + msb - 10;
                // small exponents land in the denormal range
                if (p <= 0) f = {9'd0, 23'(32'(v) << (r.expo_in + 12))};
                else f = {1'b0, 8'(p), 23'((32'(v) << (23 - msb)) & 32'h7FFFFF)};
                if (i == 0) o.red_out = f;
                else if (i == 1) o.green_out = f;
                else o.blue_out = f;
            end
        end
        return o;
    endfunction

    // queue of expected pixels, checked in order
    class pixel_scoreboard;
        t_rsp pending[$];
        int errors;

        function void note_request(t_req r);
            pending.push_back(predict_pixel(r));
        endfunction

        function void report(string what);
            $display("mismatch: %s", what);
            errors++;
        endfunction

        function void check_result(t_rsp got);
            t_rsp e;
            if (pending.size() == 0) begin
                report("unexpected result");
                return;
            end
            e = pending.pop_front();
            if (got.red_out !== e.red_out)
                report($sformatf("red_out %h exp %h", got.red_out, e.red_out));
            if (got.green_out !== e.green_out)
                report($sformatf("green_out %h exp %h", got.green_out, e.green_out));
            if (got.blue_out !== e.blue_out)
                report($sformatf("blue_out %h exp %h", got.blue_out, e.blue_out));
            if (got.mant_red_out !== e.mant_red_out)
                report($sformatf("mant_red %h exp %h", got.mant_red_out, e.mant_red_out));
            if (got.mant_green_out !== e.mant_green_out)
                report($sformatf("mant_green %h exp %h", got.mant_green_out,
                                 e.mant_green_out));
            if (got.mant_blue_out !== e.mant_blue_out)
                report($sformatf("mant_blue %h exp %h", got.mant_blue_out, e.mant_blue_out));
            if (got.expo_out !== e.expo_out)
                report($sformatf("expo %h exp %h", got.expo_out, e.expo_out));
            if (got.range_error !== e.range_error)
                report($sformatf("range_error %b exp %b", got.range_error, e.range_error));
        endfunction
    endclass
endpackage

// ----- tb/sv/tb_rgbe_shared_exponent_codec.sv -----
`timescale 1ns / 100ps
module tb_rgbe_shared_exponent_codec;
    import rgbe_pkg::*;
    import tb_rgbe_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    rgbe_stream_if #(.T(t_req)) req_if();
    rgbe_stream_if #(.T(t_rsp)) rsp_if();
    pixel_scoreboard board = new();
    int send_idle_pct = 12;
    int recv_idle_pct = 64;
    bit hold_off = 1'b0;
    bit stim_done = 1'b0;

    rgbe_shared_exponent_codec dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req_if.sink), .o_rsp(rsp_if.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // random colour component: mostly sensible floats, some specials
    function automatic logic [31:0] rand_comp(input logic [7:0] base);
        int unsigned k;
        k = $urandom_range(0, 19);
        if (k == 0) return $urandom();
        if (k == 1) return {$urandom_range(0, 1) == 1, 8'hFF, 23'($urandom())};
        if (k == 2) return {1'b1, 31'($urandom())};
        if (k == 3) return {1'b0, 8'(base - $urandom_range(0, 30)), 23'($urandom())};
        if (k == 4) return {1'b0, 8'h00, 23'($urandom())};
        return {$urandom_range(0, 9) == 0, 8'(base - $urandom_range(0, 6)), 23'($urandom())};
    endfunction

    // offer one request and wait until it is taken
    task automatic send_pixel(input t_req r);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= r;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        board.note_request(r);
    endtask

    task automatic send_encode(input logic [31:0] r, g, b);
        t_req q;
        q = t_req'($urandom());
        q.mant_red_in = 8'($urandom()); q.expo_in = 8'($urandom());
        q.command = CMD_ENCODE; q.red_in = r; q.green_in = g; q.blue_in = b;
        send_pixel(q);
    endtask

    task automatic send_decode(input logic [7:0] mr, mg, mb, ex);
        t_req q;
        q = '0;
        q.red_in = $urandom(); q.green_in = $urandom(); q.blue_in = $urandom();
        q.command = CMD_DECODE;
        q.mant_red_in = mr; q.mant_green_in = mg; q.mant_blue_in = mb; q.expo_in = ex;
        send_pixel(q);
    endtask

    task automatic send_random(input int n);
        logic [7:0] base;
        repeat (n) begin
            if ($urandom_range(0, 1)) begin
                base = (($urandom_range(0, 9) == 0) ? 8'd254 : 8'($urandom_range(10, 250)));
                send_encode(rand_comp(base), rand_comp(base), rand_comp(base));
            end else begin
                send_decode(8'($urandom()), 8'($urandom()), 8'($urandom()),
                            8'($urandom()));
            end
        end
    endtask

    // receiver: random stalls plus an optional long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) board.check_result(rsp_if.data);
            rsp_if.ready <= !hold_off && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // long receiver stall while requests keep coming
    initial begin
        wait (stim_done == 1'b0 && i_rst_n);
        repeat (300) @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (200) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin
        req_if.valid = 1'b0;
        req_if.data  = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: extremes and special cases
        send_encode(32'h3F80_0000, 32'h3F00_0000, 32'h0000_0000);
        send_encode(32'h7F80_0000, 32'h3F80_0000, 32'h3F80_0000);
        send_encode(32'h3F80_0000, 32'h7FC0_0001, 32'h3F80_0000);
        send_encode(32'h3F80_0000, 32'h3F80_0000, 32'hFF80_0000);
        send_encode(32'h7F00_0000, 32'h3F80_0000, 32'h0000_0000);
        send_encode(32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h7F7F_FFFF);
        send_encode(32'h7EFF_FFFF, 32'h7E00_0000, 32'h0000_0001);
        send_encode(32'h0A4F_B11E, 32'h0, 32'h0);
        send_encode(32'h0A4F_B11F, 32'h0A4F_B11F, 32'h0);
        send_encode(32'hBF80_0000, 32'hC000_0000, 32'h8000_0000);
        send_encode(32'hBF80_0000, 32'h4000_0000, 32'h3F80_0000);
        send_encode(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_encode(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_encode(32'h4B7F_FFFF, 32'h3F7F_FFFF, 32'h0080_0000);
        send_decode(8'h00, 8'h00, 8'h00, 8'h00);
        send_decode(8'hFF, 8'hFF, 8'hFF, 8'h00);
        send_decode(8'h00, 8'h80, 8'hFF, 8'h01);
        send_decode(8'hFF, 8'h01, 8'h00, 8'hFF);
        send_decode(8'h80, 8'h7F, 8'h55, 8'h88);
        send_decode(8'hAA, 8'h55, 8'h01, 8'h09);
        // random phases with changing idle patterns
        send_random(600);
        send_idle_pct = 64; recv_idle_pct = 12;
        send_random(600);
        send_idle_pct = 0; recv_idle_pct = 0;
        send_random(600);
        req_if.valid <= 1'b0;
        stim_done = 1'b1;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (board.errors == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end
endmodule
